@@ hdl/dtrb_pkg.sv @@
// Package for the displacement tensor row builder: types, block codes,
// index tables and small helpers. No dependencies.
package dtrb_pkg;

  localparam int NUM_LANES = 9;
  localparam int MUL_CYC   = 5;  // four partial products, then the signed accumulate

  localparam logic       ACT_SYM  = 1'b0;
  localparam logic       ACT_DISP = 1'b1;
  localparam logic [1:0] ROW_LAST = 2'd2;

  localparam logic [5:0] KIND_HDR   = 6'd0;
  localparam logic [5:0] KIND_S     = 6'd1;
  localparam logic [5:0] KIND_PAIR0 = 6'd2;
  localparam logic [5:0] KIND_TRIP0 = 6'd8;
  localparam logic [5:0] KIND_LAST  = 6'd37;

  localparam logic [63:0] HDR_VAL = 64'hFFFF_0000_0000_0000;  // -1.0 in Q15.48

  localparam logic [1:0] PAIR_A [6] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] PAIR_B [6] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};
  localparam logic [1:0] TRIP_A [10] =
    '{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] TRIP_B [10] =
    '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd2, 2'd2};
  localparam logic [1:0] TRIP_C [10] =
    '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2, 2'd1, 2'd2, 2'd2, 2'd2};

  typedef enum logic [2:0] {
    ST_IDLE, ST_ISSUE, ST_MUL, ST_RND, ST_HDR, ST_EMIT
  } state_e;

  typedef struct packed {
    logic start;   // load operands, begin a product
    logic accum;   // add onto the running sum instead of clearing it
    logic rnd;     // round and saturate the sum into the result register
    logic rnd48;   // 1: drop 48 fraction bits, 0: drop 12
  } lane_cmd_t;

  function automatic logic [3:0] s_idx(input logic [1:0] r, input logic [1:0] c);
    return 4'(r) * 4'd3 + 4'(c);
  endfunction

endpackage

@@ hdl/displacement_tensor_row_builder.sv @@
// Displacement tensor row builder, top level. Uses dtrb_pkg, dtrb_lane, dtrb_merge.
// A displacement row 2 request starts a run whose first block out is the header.
// Each displacement gives 38 blocks from nine multiply lanes in parallel; S takes
// three passes, a triplet block two; input is not ready again until the last block has
// been loaded into the output stage. Other requests are taken whenever the builder is idle.
// Reset clears both matrix stores and all control.
module displacement_tensor_row_builder (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,   // row[1:0], elem_x[33:2], elem_y[65:34], elem_z[97:66]
  input  logic [0:0]   s_axis_tuser,   // action[0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [575:0] m_axis_tdata,   // out_0[63:0] .. out_8[575:512]
  output logic [5:0]   m_axis_tuser,   // block_kind[5:0]
  output logic         m_axis_tlast    // last_block
);
  import dtrb_pkg::*;

  state_e      state_q, state_d;
  logic [5:0]  blk_q, blk_d;      // kind of the block in the works
  logic [1:0]  kterm_q, kterm_d;  // term of the S dot product
  logic        pass_q, pass_d;    // triplet: second product
  logic [2:0]  cnt_q, cnt_d;
  logic [3:0]  trip_q, trip_d;
  logic [1:0]  jsel_q, jsel_d;    // first index of a triplet split

  logic [31:0] sym_q  [9];
  logic [31:0] disp_q [9];        // row 2 is latched by the trigger request
  logic [63:0] s_q    [9];

  lane_cmd_t          cmd;
  logic signed [63:0] opa [NUM_LANES];
  logic signed [63:0] opb [NUM_LANES];
  logic signed [63:0] res [NUM_LANES];
  logic               out_free, load, hdr;
  logic               in_acc, trig;
  logic [1:0]         row;
  logic [31:0]        ex, ey, ez;
  logic [2:0]         pidx;

  assign row    = s_axis_tdata[1:0];
  assign ex     = s_axis_tdata[33:2];
  assign ey     = s_axis_tdata[65:34];
  assign ez     = s_axis_tdata[97:66];
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign trig   = in_acc && s_axis_tuser[0] == ACT_DISP && row == ROW_LAST;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign pidx   = 3'(blk_q - KIND_PAIR0);

  // matrix stores; a row index of three touches nothing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < 9; e++) begin
        sym_q[e]  <= '0;
        disp_q[e] <= '0;
      end
    end else if (in_acc && row != 2'd3) begin
      if (s_axis_tuser[0] == ACT_SYM) begin
        sym_q[s_idx(row, 2'd0)] <= ex;
        sym_q[s_idx(row, 2'd1)] <= ey;
        sym_q[s_idx(row, 2'd2)] <= ez;
      end else begin
        disp_q[s_idx(row, 2'd0)] <= ex;
        disp_q[s_idx(row, 2'd1)] <= ey;
        disp_q[s_idx(row, 2'd2)] <= ez;
      end
    end
  end

  // S stays fixed while the product blocks are built
  always_ff @(posedge clk_i) begin
    if (state_q == ST_HDR) begin
      for (int m = 0; m < NUM_LANES; m++) s_q[m] <= res[m];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      blk_q   <= '0;
      kterm_q <= '0;
      pass_q  <= 1'b0;
      cnt_q   <= '0;
      trip_q  <= '0;
      jsel_q  <= '0;
    end else begin
      state_q <= state_d;
      blk_q   <= blk_d;
      kterm_q <= kterm_d;
      pass_q  <= pass_d;
      cnt_q   <= cnt_d;
      trip_q  <= trip_d;
      jsel_q  <= jsel_d;
    end
  end

  // sequencer: per block issue and wait out each product, round, emit (header before S)
  always_comb begin
    state_d = state_q;
    blk_d   = blk_q;
    kterm_d = kterm_q;
    pass_d  = pass_q;
    cnt_d   = cnt_q;
    trip_d  = trip_q;
    jsel_d  = jsel_q;
    cmd     = '0;
    load    = 1'b0;
    hdr     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (trig) begin
          blk_d   = KIND_S;
          kterm_d = '0;
          pass_d  = 1'b0;
          trip_d  = '0;
          jsel_d  = '0;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd.start = 1'b1;
        cmd.accum = (blk_q == KIND_S) && (kterm_q != 2'd0);
        cnt_d     = '0;
        state_d   = ST_MUL;
      end
      ST_MUL: begin
        if (cnt_q == 3'(MUL_CYC - 1)) begin
          if (blk_q == KIND_S && kterm_q != 2'd2) begin
            kterm_d = kterm_q + 2'd1;
            state_d = ST_ISSUE;
          end else begin
            state_d = ST_RND;
          end
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      ST_RND: begin
        cmd.rnd   = 1'b1;
        cmd.rnd48 = (blk_q != KIND_S);
        if (blk_q == KIND_S) begin
          state_d = ST_HDR;
        end else if (blk_q >= KIND_TRIP0 && !pass_q) begin
          pass_d  = 1'b1;
          state_d = ST_ISSUE;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_HDR: begin
        if (out_free) begin
          load    = 1'b1;
          hdr     = 1'b1;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load = 1'b1;
          if (blk_q == KIND_LAST) begin
            state_d = ST_IDLE;
          end else begin
            blk_d   = blk_q + 6'd1;
            pass_d  = 1'b0;
            state_d = ST_ISSUE;
            if (blk_q >= KIND_TRIP0) begin
              if (jsel_q == 2'd2) begin
                jsel_d = '0;
                trip_d = trip_q + 4'd1;
              end else begin
                jsel_d = jsel_q + 2'd1;
              end
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // lanes: lane m owns output slot m, row part m/3, column part m%3
  for (genvar m = 0; m < NUM_LANES; m++) begin : g_lane
    localparam logic [1:0] RI = 2'(m / 3);
    localparam logic [1:0] CI = 2'(m % 3);
    logic [31:0] sv, uv;

    always_comb begin
      sv = sym_q[s_idx(CI, kterm_q)];
      uv = disp_q[s_idx(RI, kterm_q)];
      if (blk_q == KIND_S) begin
        opa[m] = {{32{sv[31]}}, sv};
        opb[m] = {{32{uv[31]}}, uv};
      end else if (blk_q < KIND_TRIP0) begin
        opa[m] = s_q[s_idx(PAIR_A[pidx], RI)];
        opb[m] = s_q[s_idx(PAIR_B[pidx], CI)];
      end else if (!pass_q) begin
        opa[m] = s_q[s_idx(TRIP_A[trip_q], jsel_q)];
        opb[m] = s_q[s_idx(TRIP_B[trip_q], RI)];
      end else begin
        opa[m] = res[m];
        opb[m] = s_q[s_idx(TRIP_C[trip_q], CI)];
      end
    end

    dtrb_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .a_i    (opa[m]),
      .b_i    (opb[m]),
      .res_o  (res[m])
    );
  end

  dtrb_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .hdr_i         (hdr),
    .kind_i        (hdr ? KIND_HDR : blk_q),
    .last_i        (!hdr && blk_q == KIND_LAST),
    .vals_i        (res),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

@@ hdl/dtrb_lane.sv @@
// One multiply-accumulate lane: 64x64 signed product in four 32x32 steps,
// 128-bit running sum, round half up and saturate. Depends on dtrb_pkg.
module dtrb_lane (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dtrb_pkg::lane_cmd_t      cmd_i,
  input  logic signed [63:0]       a_i,
  input  logic signed [63:0]       b_i,
  output logic signed [63:0]       res_o
);
  import dtrb_pkg::*;

  logic [63:0]  ua_q, ub_q;
  logic         neg_q;
  logic [2:0]   step_q;
  logic         busy_q;
  logic [127:0] prod_q, acc_q;
  logic [63:0]  res_q;

  logic [31:0]  ah, bh;
  logic [63:0]  pp;
  logic [127:0] pp_sh, t12, t48;
  logic         ok12, ok48;
  logic [63:0]  r12, r48;

  always_comb begin
    ah = step_q[1] ? ua_q[63:32] : ua_q[31:0];
    bh = step_q[0] ? ub_q[63:32] : ub_q[31:0];
    pp = 64'(ah) * 64'(bh);
    unique case (step_q)
      3'd0:       pp_sh = {64'd0, pp};
      3'd1, 3'd2: pp_sh = {32'd0, pp, 32'd0};
      3'd3:       pp_sh = {pp, 64'd0};
      default:    pp_sh = '0;
    endcase
    t12  = acc_q + (128'd1 << 11);
    t48  = acc_q + (128'd1 << 47);
    ok12 = (&t12[127:75]) | ~(|t12[127:75]);
    ok48 = (&t48[127:111]) | ~(|t48[127:111]);
    r12  = ok12 ? t12[75:12] : (t12[127] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF);
    r48  = ok48 ? t48[111:48] : (t48[127] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (cmd_i.start) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 3'd1;
      if (step_q == 3'd4) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      ua_q   <= a_i[63] ? 64'd0 - 64'(a_i) : 64'(a_i);
      ub_q   <= b_i[63] ? 64'd0 - 64'(b_i) : 64'(b_i);
      neg_q  <= a_i[63] ^ b_i[63];
      prod_q <= '0;
      if (!cmd_i.accum) acc_q <= '0;
    end else if (busy_q) begin
      if (step_q == 3'd4) acc_q <= acc_q + (prod_q ^ {128{neg_q}}) + 128'(neg_q);
      else                prod_q <= prod_q + pp_sh;
    end
    if (cmd_i.rnd) res_q <= cmd_i.rnd48 ? r48 : r12;
  end

  assign res_o = res_q;

endmodule

@@ hdl/dtrb_merge.sv @@
// Output stage: gathers the nine lane results (or the header constant) into
// one registered result block on the master stream. Depends on dtrb_pkg.
module dtrb_merge (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic               hdr_i,
  input  logic [5:0]         kind_i,
  input  logic               last_i,
  input  logic signed [63:0] vals_i [9],
  output logic               free_o,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [575:0]       m_axis_tdata,
  output logic [5:0]         m_axis_tuser,
  output logic               m_axis_tlast
);
  import dtrb_pkg::*;

  logic        valid_q;
  logic [5:0]  kind_q;
  logic        last_q;
  logic [63:0] val_q [NUM_LANES];

  assign free_o = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (load_i) valid_q <= 1'b1;
    else if (m_axis_tready) valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      kind_q <= kind_i;
      last_q <= last_i;
      for (int m = 0; m < NUM_LANES; m++) begin
        if (hdr_i) val_q[m] <= (m == 0) ? HDR_VAL : 64'd0;
        else       val_q[m] <= vals_i[m];
      end
    end
  end

  always_comb begin
    for (int m = 0; m < NUM_LANES; m++) m_axis_tdata[64*m +: 64] = val_q[m];
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tlast  = last_q;

endmodule

@@ hdl/dtrb_checker.sv @@
// Port-level checks for the displacement tensor row builder, bound to the
// top level. Depends on dtrb_pkg.
module dtrb_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [575:0] m_axis_tdata,
  input logic [5:0]   m_axis_tuser,
  input logic         m_axis_tlast
);
  import dtrb_pkg::*;

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == KIND_LAST)))
    else $error("tlast does not match final block");

  a_hdr_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_HDR) |->
      (m_axis_tdata[63:0] == HDR_VAL && m_axis_tdata[575:64] == '0))
    else $error("bad header block");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
    else $error("input taken mid-run");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tuser)))
    else $error("stalled result dropped");

endmodule

bind displacement_tensor_row_builder dtrb_checker u_dtrb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
